// ===== src/byte_rate_meter_defines.svh =====
// Assertion macros for the byte rate meter.
`ifndef BYTE_RATE_METER_DEFINES_SVH
`define BYTE_RATE_METER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte_rate_meter: implication check failed");
`define BRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte_rate_meter: next-cycle check failed");
`else
`define BRM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BRM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/brm_pkg.sv =====
// Shared types and constants for the byte rate meter.
package brm_pkg;

   localparam int DATA_W  = 32;
   localparam int THR_W   = 31;
   localparam int CNT_W   = $clog2(DATA_W);
   localparam int CSR_IDX_W = 1;

   localparam logic [THR_W-1:0]     THRESHOLD_RESET = 31'h0000_C7FF;
   localparam logic [DATA_W-1:0]    INIT_TIME_RESET = 32'd0;
   localparam logic [DATA_W-1:0]    SCALE_MS_PER_S  = 32'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TIME = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } brm_div_sts_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ADD   = 5'b00010,
      S_CHECK = 5'b00100,
      S_DIV   = 5'b01000,
      S_DONE  = 5'b10000
   } brm_state_type;

endpackage

// ===== src/brm_div.sv =====
// Iterative restoring unsigned divider, one quotient bit per cycle.
module brm_div
   import brm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DATA_W-1:0]    dividend,
   input  logic [DATA_W-1:0]    divisor,
   output logic [DATA_W-1:0]    quotient,
   output brm_div_sts_type      sts
);

   logic [DATA_W-1:0] rem_ff,  rem_in;
   logic [DATA_W-1:0] quo_ff,  quo_in;
   logic [DATA_W-1:0] dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DATA_W-1]};
      diff  = trial - {1'b0, dvsr_ff};
      fits  = (trial >= {1'b0, dvsr_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// ===== src/byte_rate_meter.sv =====
// Top level of the byte rate meter: window accumulation, sequencer, output register.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_amount, req_now_ms
//  rsp      out        rsp_valid / rsp_stall  rsp_bytes_per_second
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// An item without a rate update passes through S_ADD, S_CHECK and S_DONE to the result;
// one that recomputes the rate also waits in S_DIV for the 32-step divider.
// Reset clears the window total and rate, loads the threshold default and
// a window start of zero. A stalled result holds; the next item is taken
// while it waits, and its result is held back until the register frees.
`include "byte_rate_meter_defines.svh"

module byte_rate_meter
   import brm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [DATA_W-1:0]   req_amount,
   input  logic        [DATA_W-1:0]   req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_bytes_per_second,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [DATA_W-1:0]          csr_data
);

   brm_state_type      state_ff, state_in;
   logic [DATA_W-1:0]  amount_ff, amount_in;
   logic [DATA_W-1:0]  now_ff, now_in;
   logic [DATA_W-1:0]  window_bytes_ff, window_bytes_in;
   logic [DATA_W-1:0]  window_start_ms_ff, window_start_ms_in;
   logic [DATA_W-1:0]  elapsed_ff, elapsed_in;
   logic [DATA_W-1:0]  last_rate_ff, last_rate_in;
   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               csr_xfer;
   logic               above;
   logic               div_start;
   logic [DATA_W-1:0]  scaled;
   logic [DATA_W-1:0]  quotient;
   brm_div_sts_type    div_sts;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   assign above  = !window_bytes_ff[DATA_W-1] &&
                   (window_bytes_ff[THR_W-1:0] > threshold_ff);
   assign scaled = window_bytes_ff * SCALE_MS_PER_S;

   always_comb begin
      state_in           = state_ff;
      amount_in          = amount_ff;
      now_in             = now_ff;
      window_bytes_in    = window_bytes_ff;
      window_start_ms_in = window_start_ms_ff;
      elapsed_in         = elapsed_ff;
      last_rate_in       = last_rate_ff;
      threshold_in       = threshold_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_data_in        = rsp_data_ff;
      div_start          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               amount_in = req_amount;
               now_in    = req_now_ms;
               state_in  = S_ADD;
            end
         end
         S_ADD: begin
            window_bytes_in = window_bytes_ff + amount_ff;
            elapsed_in      = now_ff - window_start_ms_ff;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            if (above && (elapsed_ff != '0)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in  = S_DONE;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               last_rate_in       = quotient;
               window_start_ms_in = now_ff;
               window_bytes_in    = '0;
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = last_rate_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_xfer) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in       = csr_data[THR_W-1:0];
            CSR_INIT_TIME: window_start_ms_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         window_bytes_ff    <= '0;
         window_start_ms_ff <= INIT_TIME_RESET;
         last_rate_ff       <= '0;
         threshold_ff       <= THRESHOLD_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         window_bytes_ff    <= window_bytes_in;
         window_start_ms_ff <= window_start_ms_in;
         last_rate_ff       <= last_rate_in;
         threshold_ff       <= threshold_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amount_ff   <= amount_in;
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      rsp_data_ff <= rsp_data_in;
   end

   brm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled),
      .divisor  (elapsed_ff),
      .quotient (quotient),
      .sts      (div_sts)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bytes_per_second = rsp_data_ff;

   `BRM_ASSERT_IMPLY(a_div_running, clock, reset, state_ff == S_DIV, div_sts.busy || div_sts.done)
   `BRM_ASSERT_IMPLY(a_done_in_div, clock, reset, div_sts.done, state_ff == S_DIV)
   `BRM_ASSERT_NEXT(a_window_restart, clock, reset, div_sts.done, window_bytes_ff == '0)
   `BRM_ASSERT_NEXT(a_rsp_load, clock, reset, (state_ff == S_DONE) && !rsp_valid_ff, rsp_valid_ff)

endmodule

// ===== verif/brm_rate_checker.sv =====
// Transfer monitor and rate predictor for the byte rate meter testbench.
module brm_rate_checker
   import brm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_amount,
   input  logic        [DATA_W-1:0] req_now_ms,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_bytes_per_second,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   output int                       fail_count,
   output int                       pending
);

   logic [THR_W-1:0]  threshold;
   logic [DATA_W-1:0] window_total;
   logic [DATA_W-1:0] window_start;
   logic [DATA_W-1:0] rate;
   logic [DATA_W-1:0] expected_rates[$];

   task automatic report(input string msg);
      $display("[%0t] rate mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [DATA_W-1:0] rate_after(input logic [DATA_W-1:0] amount,
                                                    input logic [DATA_W-1:0] now);
      logic [DATA_W-1:0] elapsed;
      logic [DATA_W-1:0] scaled;
      window_total = window_total + amount;
      if (!window_total[DATA_W-1] && window_total > {1'b0, threshold}) begin
         elapsed = now - window_start;
         if (elapsed != '0) begin
            scaled       = window_total * SCALE_MS_PER_S;
            rate         = scaled / elapsed;
            window_start = now;
            window_total = '0;
         end
      end
      return rate;
   endfunction

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         threshold    = THRESHOLD_RESET;
         window_start = INIT_TIME_RESET;
         window_total = '0;
         rate         = '0;
         expected_rates.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rates.size() == 0) begin
               report($sformatf("result %h with nothing pending", rsp_bytes_per_second));
            end else begin
               want = expected_rates.pop_front();
               if (rsp_bytes_per_second !== want)
                  report($sformatf("bytes_per_second %h, want %h",
                                   rsp_bytes_per_second, want));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: begin
                  threshold = csr_data[THR_W-1:0];
               end
               CSR_INIT_TIME: begin
                  window_start = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall)
            expected_rates.push_back(rate_after(req_amount, req_now_ms));
      end
      pending = expected_rates.size();
   end

endmodule

// ===== verif/tb_byte_rate_meter.sv =====
// Testbench top for the byte rate meter: clock, reset, stimulus and verdict.
module tb_byte_rate_meter;
   import brm_pkg::*;

   localparam int LIMIT = 800000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_amount = '0;
   logic        [DATA_W-1:0] req_now_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_bytes_per_second;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_THRESHOLD;
   logic [DATA_W-1:0]        csr_data = '0;

   int   fail_count;
   int   pending;
   int   cycles = 0;
   logic no_idle = 1'b0;
   logic hold_rsp = 1'b0;

   byte_rate_meter uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_amount           (req_amount),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bytes_per_second (rsp_bytes_per_second),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   brm_rate_checker rate_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_amount           (req_amount),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bytes_per_second (rsp_bytes_per_second),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .fail_count           (fail_count),
      .pending              (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_packet(input logic [DATA_W-1:0] amount, input logic [DATA_W-1:0] now);
      int gap;
      gap = no_idle ? 0 : $urandom_range(19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_amount <= amount;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic configure(input logic [DATA_W-1:0] thr_data,
                            input logic [DATA_W-1:0] start_ms);
      csr_valid <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_data  <= thr_data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_INIT_TIME;
      csr_data  <= start_ms;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // result side: random hold-off per transfer, one long hold on request
   initial begin
      int k;
      forever begin
         if (hold_rsp) begin
            k = 600;
            hold_rsp = 1'b0;
         end else if (no_idle) begin
            k = 0;
         end else begin
            k = $urandom_range(19);
         end
         if (k > 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [DATA_W-1:0] thr_data;
      logic [DATA_W-1:0] thr;
      logic [DATA_W-1:0] start_ms;
      logic [DATA_W-1:0] now;
      logic [DATA_W-1:0] amount;
      int                r;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: threshold edge, zero elapsed, negatives, wrap, backward time
      send_packet(32'd51199, 32'd5);
      send_packet(32'd1, 32'd0);
      send_packet(32'd0, 32'd10);
      send_packet(-32'sd100, 32'd20);
      send_packet(32'h8000_0000, 32'd30);
      send_packet(32'h7FFF_FFFF, 32'd40);
      send_packet(32'h7FFF_FFFF, 32'd50);
      send_packet(32'd60000, 32'd7);
      send_packet(32'd60000, 32'hFFFF_FFFF);
      drain();

      // zero threshold (upper data bit masked), start at top of time range
      configure(32'h8000_0000, 32'hFFFF_FFFF);
      send_packet(32'd1, 32'hFFFF_FFFF);
      send_packet(32'd1, 32'd0);
      send_packet(32'd0, 32'd1);
      send_packet(32'h7FFF_FFFF, 32'd2);
      send_packet(32'hFFFF_FFFF, 32'd3);
      drain();

      // largest threshold: no total can pass it
      configure(32'hFFFF_FFFF, 32'd0);
      send_packet(32'h7FFF_FFFF, 32'd100);
      send_packet(32'h7FFF_FFFF, 32'd200);
      send_packet(32'd2, 32'd300);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         start_ms = $urandom;
         case (phase)
            0: thr_data = $urandom_range(5000);
            1: thr_data = 32'd51199;
            2: thr_data = $urandom;
            3: begin
               thr_data = 32'd0;
               start_ms = 32'hFFFF_FFF0;
            end
            4: thr_data = $urandom_range(200000, 1000);
            default: thr_data = 32'h7FFF_FFFF;
         endcase
         configure(thr_data, start_ms);
         thr      = {1'b0, thr_data[THR_W-1:0]};
         now      = start_ms + $urandom_range(3);
         no_idle  = (phase == 3);
         hold_rsp = (phase == 1);
         for (int i = 0; i < 230; i++) begin
            r = $urandom_range(99);
            if (r < 80)
               amount = $urandom_range(thr / 8 + 2);
            else if (r < 90)
               amount = -$urandom_range(5000, 1);
            else
               amount = $urandom;
            if ($urandom_range(99) < 88)
               now = now + $urandom_range(40);
            else
               now = $urandom;
            send_packet(amount, now);
         end
         no_idle = 1'b0;
      end

      req_valid <= 1'b0;
      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== byte_rate_meter.f =====
+incdir+src
src/brm_pkg.sv
src/brm_div.sv
src/byte_rate_meter.sv
verif/brm_rate_checker.sv
verif/tb_byte_rate_meter.sv
